@@ hdl/polyphase_fir_front_end_defines.svh @@
// Assertion macros shared by the filterbank front end.
`ifndef POLYPHASE_FIR_FRONT_END_DEFINES_SVH
`define POLYPHASE_FIR_FRONT_END_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PFE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pfe: check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfe: check failed");
`else
`define PFE_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PFE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/pfe_pkg.sv @@
package pfe_pkg;

    // Default filter geometry
    localparam int unsigned NTAPS_DEF = 8;
    localparam int unsigned NFFT_DEF  = 1024;

    // Field widths
    localparam int unsigned COEF_IDX_W = 13;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned SAMP_W     = 16;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned ACC_W      = 35;
    localparam int unsigned CHAN_OUT_W = 10;

    // Input tdata layout, lowest bit first
    localparam int unsigned COEF_IDX_LSB = 0;
    localparam int unsigned COEF_VAL_LSB = COEF_IDX_LSB + COEF_IDX_W;
    localparam int unsigned SAMP_RE_LSB  = COEF_VAL_LSB + COEF_W;
    localparam int unsigned SAMP_IM_LSB  = SAMP_RE_LSB + SAMP_W;
    localparam int unsigned IN_DATA_W    = 64;

    // Output tdata: filt_re, filt_im, channel
    localparam int unsigned OUT_DATA_W = 2 * ACC_W + CHAN_OUT_W;

    // tuser codes on the input side
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // One tap issued to the memories, followed down the datapath
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic use_hist;
    } issue_t;

endpackage

@@ hdl/pfe_ram.sv @@
module pfe_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pfe_mac.sv @@
module pfe_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pfe_pkg::issue_t                      iss,
    input  logic signed [pfe_pkg::COEF_W-1:0]    wt_rdata,
    input  logic [2*pfe_pkg::SAMP_W-1:0]         hist_rdata,
    input  logic signed [pfe_pkg::SAMP_W-1:0]    x_re,
    input  logic signed [pfe_pkg::SAMP_W-1:0]    x_im,
    output logic signed [pfe_pkg::ACC_W-1:0]     acc_re,
    output logic signed [pfe_pkg::ACC_W-1:0]     acc_im,
    output logic                                 acc_done
);
    import pfe_pkg::*;

    issue_t                   rd_reg;
    issue_t                   mul_reg;
    logic signed [SAMP_W-1:0] op_re;
    logic signed [SAMP_W-1:0] op_im;
    logic signed [PROD_W-1:0] prod_re;
    logic signed [PROD_W-1:0] prod_im;
    logic signed [PROD_W-1:0] mul_re_reg;
    logic signed [PROD_W-1:0] mul_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  base_re;
    logic signed [ACC_W-1:0]  base_im;
    logic                     done_reg;

    // Align tap control with the registered memory read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            mul_reg <= '0;
        end else begin
            rd_reg  <= iss;
            mul_reg <= rd_reg;
        end
    end

    // Pick the operand: newest sample on the last tap, history otherwise,
    // zero for frames not yet seen since reset
    always_comb begin
        if (rd_reg.last) begin
            op_re = x_re;
            op_im = x_im;
        end else if (rd_reg.use_hist) begin
            op_re = $signed(hist_rdata[SAMP_W-1:0]);
            op_im = $signed(hist_rdata[2*SAMP_W-1:SAMP_W]);
        end else begin
            op_re = '0;
            op_im = '0;
        end
        prod_re = wt_rdata * op_re;
        prod_im = wt_rdata * op_im;
    end

    // Register products
    always_ff @(posedge aclk) begin
        mul_re_reg <= prod_re;
        mul_im_reg <= prod_im;
    end

    // Accumulate; first tap restarts the sum
    always_comb begin
        base_re = mul_reg.first ? '0 : acc_re_reg;
        base_im = mul_reg.first ? '0 : acc_im_reg;
    end

    always_ff @(posedge aclk) begin
        if (mul_reg.vld) begin
            acc_re_reg <= base_re + ACC_W'(mul_re_reg);
            acc_im_reg <= base_im + ACC_W'(mul_im_reg);
        end
    end

    // Flag a finished sum until the next item starts issuing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (iss.vld && iss.first) begin
            done_reg <= 1'b0;
        end else if (mul_reg.vld && mul_reg.last) begin
            done_reg <= 1'b1;
        end
    end

    assign acc_re   = acc_re_reg;
    assign acc_im   = acc_im_reg;
    assign acc_done = done_reg;

endmodule

@@ hdl/pfe_ctrl.sv @@
`include "polyphase_fir_front_end_defines.svh"

module pfe_ctrl #(
    parameter int unsigned NTAPS = pfe_pkg::NTAPS_DEF,
    parameter int unsigned NFFT  = pfe_pkg::NFFT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pfe_pkg::IN_DATA_W-1:0]          s_tdata,
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pfe_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    output logic                                   wt_we,
    output logic [$clog2(NTAPS*NFFT)-1:0]          wt_waddr,
    output logic [pfe_pkg::COEF_W-1:0]             wt_wdata,
    output logic [$clog2(NTAPS*NFFT)-1:0]          wt_raddr,
    output logic                                   hist_we,
    output logic [$clog2((NTAPS-1)*NFFT)-1:0]      hist_waddr,
    output logic [2*pfe_pkg::SAMP_W-1:0]           hist_wdata,
    output logic [$clog2((NTAPS-1)*NFFT)-1:0]      hist_raddr,
    output pfe_pkg::issue_t                        iss,
    output logic signed [pfe_pkg::SAMP_W-1:0]      x_re,
    output logic signed [pfe_pkg::SAMP_W-1:0]      x_im,
    input  logic signed [pfe_pkg::ACC_W-1:0]       acc_re,
    input  logic signed [pfe_pkg::ACC_W-1:0]       acc_im,
    input  logic                                   acc_done
);
    import pfe_pkg::*;

    localparam int unsigned HIST_FRAMES = NTAPS - 1;
    localparam int unsigned HIST_DEPTH  = HIST_FRAMES * NFFT;
    localparam int unsigned WT_DEPTH    = NTAPS * NFFT;
    localparam int unsigned CHAN_W      = $clog2(NFFT);
    localparam int unsigned HA_W        = $clog2(HIST_DEPTH);
    localparam int unsigned WA_W        = $clog2(WT_DEPTH);
    localparam int unsigned TAP_W       = $clog2(NTAPS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [TAP_W-1:0]         tap_reg, tap_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic [HA_W-1:0]          hbase_reg, hbase_next;
    logic [TAP_W-1:0]         frames_reg, frames_next;
    logic [WA_W-1:0]          wptr_reg, wptr_next;
    logic [HA_W-1:0]          hptr_reg, hptr_next;
    logic signed [SAMP_W-1:0] x_re_reg;
    logic signed [SAMP_W-1:0] x_im_reg;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tlast_reg;

    logic                     accept;
    logic                     smp_accept;
    logic [COEF_IDX_W-1:0]    f_coef_idx;
    logic [COEF_W-1:0]        f_coef_val;
    logic [SAMP_W-1:0]        f_re;
    logic [SAMP_W-1:0]        f_im;
    logic                     tap_last;
    logic                     hist_ok;
    logic                     chan_last;
    logic                     emit;
    logic [HA_W:0]            hsum;
    logic [HA_W:0]            bsum;
    logic [31:0]              chan_wide;

    // Unpack the input transfer
    assign f_coef_idx = s_tdata[COEF_IDX_LSB +: COEF_IDX_W];
    assign f_coef_val = s_tdata[COEF_VAL_LSB +: COEF_W];
    assign f_re       = s_tdata[SAMP_RE_LSB +: SAMP_W];
    assign f_im       = s_tdata[SAMP_IM_LSB +: SAMP_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign smp_accept = accept && (s_tuser == FUNC_SAMPLE);

    // Coefficient load goes straight into the weight store
    assign wt_we    = accept && (s_tuser == FUNC_LOAD) && (32'(f_coef_idx) < WT_DEPTH);
    assign wt_waddr = WA_W'(f_coef_idx);
    assign wt_wdata = f_coef_val;

    // Tap issue
    assign tap_last  = (tap_reg == TAP_W'(NTAPS - 1));
    assign hist_ok   = (({1'b0, frames_reg} + {1'b0, tap_reg}) >= (TAP_W + 1)'(NTAPS - 1));
    assign chan_last = (chan_reg == CHAN_W'(NFFT - 1));

    always_comb begin
        iss.vld      = (state_reg == ST_ISSUE);
        iss.first    = (tap_reg == '0);
        iss.last     = tap_last;
        iss.use_hist = !tap_last && hist_ok;
    end

    assign wt_raddr   = wptr_reg;
    assign hist_raddr = hptr_reg;

    // Overwrite the oldest frame's entry once its read is issued
    assign hist_we    = (state_reg == ST_ISSUE) && tap_last;
    assign hist_waddr = hbase_reg + HA_W'(chan_reg);
    assign hist_wdata = {x_im_reg, x_re_reg};

    assign x_re = x_re_reg;
    assign x_im = x_im_reg;

    // Ring pointer steps, wrapped at the history depth
    always_comb begin
        hsum = {1'b0, hptr_reg} + (HA_W + 1)'(NFFT);
        if (hsum >= (HA_W + 1)'(HIST_DEPTH)) begin
            hsum = hsum - (HA_W + 1)'(HIST_DEPTH);
        end
        bsum = {1'b0, hbase_reg} + (HA_W + 1)'(NFFT);
        if (bsum >= (HA_W + 1)'(HIST_DEPTH)) begin
            bsum = '0;
        end
    end

    assign emit      = (state_reg == ST_DRAIN) && acc_done && (!m_tvalid_reg || m_tready);
    assign chan_wide = 32'(chan_reg);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        chan_next     = chan_reg;
        hbase_next    = hbase_reg;
        frames_next   = frames_reg;
        wptr_next     = wptr_reg;
        hptr_next     = hptr_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (smp_accept) begin
                    tap_next   = '0;
                    wptr_next  = WA_W'(chan_reg);
                    hptr_next  = hbase_reg + HA_W'(chan_reg);
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                tap_next  = tap_reg + 1'b1;
                wptr_next = wptr_reg + WA_W'(NFFT);
                hptr_next = hsum[HA_W-1:0];
                if (tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (emit) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (chan_last) begin
                        chan_next  = '0;
                        hbase_next = bsum[HA_W-1:0];
                        if (frames_reg != TAP_W'(HIST_FRAMES)) begin
                            frames_next = frames_reg + 1'b1;
                        end
                    end else begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            chan_reg     <= '0;
            hbase_reg    <= '0;
            frames_reg   <= '0;
            wptr_reg     <= '0;
            hptr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            chan_reg     <= chan_next;
            hbase_reg    <= hbase_next;
            frames_reg   <= frames_next;
            wptr_reg     <= wptr_next;
            hptr_reg     <= hptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the sample for the whole item; load the result on emit
    always_ff @(posedge aclk) begin
        if (smp_accept) begin
            x_re_reg <= $signed(f_re);
            x_im_reg <= $signed(f_im);
        end
        if (emit) begin
            m_tdata_reg <= {chan_wide[CHAN_OUT_W-1:0], acc_im, acc_re};
            m_tlast_reg <= chan_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `PFE_ASSERT_NOW(a_wt_port_excl, aclk, aresetn, wt_we, !iss.vld)
    `PFE_ASSERT_NEXT(a_sample_starts, aclk, aresetn, smp_accept, (state_reg == ST_ISSUE) && (tap_reg == '0))
    `PFE_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, emit && chan_last, (chan_reg == '0) && m_tlast)

endmodule

@@ hdl/polyphase_fir_front_end.sv @@
// Weighted-tap stage of a polyphase filterbank. A transfer with tuser low loads one
// window coefficient (address tap*NFFT+channel, ignored when out of range); the user
// must load all coefficients before samples flow; the block does not enforce it. A
// transfer with tuser high carries one complex Q15 sample and yields one result: the
// full-precision Q30 sum over the NTAPS taps of coefficient times the same channel's
// sample from successive earlier frames, the newest sample on the last tap, with
// channel and a last-of-frame flag (tlast). The single multiply-accumulate unit reads
// one tap per cycle from the weight and history memories; a new transfer waits until
// the result is registered. History reads for frames not yet received since reset
// return zero through a frame fill count, so no clearing pass follows reset. The
// result register lets the next sample proceed while a result waits on m_tready.
module polyphase_fir_front_end #(
    parameter int unsigned NTAPS = pfe_pkg::NTAPS_DEF,
    parameter int unsigned NFFT  = pfe_pkg::NFFT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coef_index[12:0], coef_value[28:13], sample_re[44:29], sample_im[60:45], zero pad
    input  logic [pfe_pkg::IN_DATA_W-1:0]     s_tdata,
    // func: 0 loads a coefficient, 1 presents a sample
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // filt_re[34:0], filt_im[69:35], channel[79:70]
    output logic [pfe_pkg::OUT_DATA_W-1:0]    m_tdata,
    // frame_end
    output logic                              m_tlast
);
    import pfe_pkg::*;

    localparam int unsigned HIST_DEPTH = (NTAPS - 1) * NFFT;
    localparam int unsigned WT_DEPTH   = NTAPS * NFFT;
    localparam int unsigned HA_W       = $clog2(HIST_DEPTH);
    localparam int unsigned WA_W       = $clog2(WT_DEPTH);

    logic                     wt_we;
    logic [WA_W-1:0]          wt_waddr;
    logic [COEF_W-1:0]        wt_wdata;
    logic [WA_W-1:0]          wt_raddr;
    logic [COEF_W-1:0]        wt_rdata;
    logic                     hist_we;
    logic [HA_W-1:0]          hist_waddr;
    logic [2*SAMP_W-1:0]      hist_wdata;
    logic [HA_W-1:0]          hist_raddr;
    logic [2*SAMP_W-1:0]      hist_rdata;
    issue_t                   iss;
    logic signed [SAMP_W-1:0] x_re;
    logic signed [SAMP_W-1:0] x_im;
    logic signed [ACC_W-1:0]  acc_re;
    logic signed [ACC_W-1:0]  acc_im;
    logic                     acc_done;

    pfe_ctrl #(
        .NTAPS (NTAPS),
        .NFFT  (NFFT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .wt_we      (wt_we),
        .wt_waddr   (wt_waddr),
        .wt_wdata   (wt_wdata),
        .wt_raddr   (wt_raddr),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_raddr (hist_raddr),
        .iss        (iss),
        .x_re       (x_re),
        .x_im       (x_im),
        .acc_re     (acc_re),
        .acc_im     (acc_im),
        .acc_done   (acc_done)
    );

    // Window coefficients
    pfe_ram #(
        .WIDTH (COEF_W),
        .DEPTH (WT_DEPTH)
    ) u_wt_ram (
        .clk   (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    // Sample history ring, NTAPS-1 frames of {im, re}
    pfe_ram #(
        .WIDTH (2 * SAMP_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    pfe_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .iss        (iss),
        .wt_rdata   ($signed(wt_rdata)),
        .hist_rdata (hist_rdata),
        .x_re       (x_re),
        .x_im       (x_im),
        .acc_re     (acc_re),
        .acc_im     (acc_im),
        .acc_done   (acc_done)
    );

endmodule

@@ tb/polyphase_fir_checker.sv @@
// Watches both channels of the filterbank front end, predicts each weighted tap
// sum from its own copy of the coefficient and history stores, and compares.
module polyphase_fir_checker #(
    parameter int unsigned NTAPS = pfe_pkg::NTAPS_DEF,
    parameter int unsigned NFFT  = pfe_pkg::NFFT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pfe_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pfe_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending,
    output int                             result_count,
    output int                             load_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam int unsigned HIST_FRAMES = NTAPS - 1;
    localparam int unsigned HIST_DEPTH  = HIST_FRAMES * NFFT;
    localparam int unsigned WEIGHT_DEPTH = NTAPS * NFFT;

    typedef struct {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic [CHAN_OUT_W-1:0]   chan;
        logic                    last;
    } tap_sum_t;

    // Predictor state
    logic signed [SAMP_W-1:0] hist_re [HIST_DEPTH];
    logic signed [SAMP_W-1:0] hist_im [HIST_DEPTH];
    logic signed [COEF_W-1:0] weights [WEIGHT_DEPTH];
    int unsigned              chan_pos;
    int unsigned              oldest_frame;
    tap_sum_t                 expected_sums [$];

    int          fails;
    int          results;
    int          loads;
    int unsigned load_addr;
    tap_sum_t    got;
    tap_sum_t    want;

    // History is clear after reset
    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
        end
        for (int i = 0; i < WEIGHT_DEPTH; i++) weights[i] = '0;
        chan_pos     = 0;
        oldest_frame = 0;
        fails        = 0;
        results      = 0;
        loads        = 0;
    end

    // Sum the taps for the current channel, then store the sample and advance
    function automatic tap_sum_t weighted_tap_sum(logic signed [SAMP_W-1:0] x_re,
                                                  logic signed [SAMP_W-1:0] x_im);
        tap_sum_t    r;
        longint      acc_re;
        longint      acc_im;
        int unsigned slot;
        int unsigned h;
        acc_re = 0;
        acc_im = 0;
        slot   = oldest_frame;
        // Oldest stored frame meets tap 0
        for (int t = 0; t < HIST_FRAMES; t++) begin
            h = slot * NFFT + chan_pos;
            acc_re += longint'(weights[t * NFFT + chan_pos]) * longint'(hist_re[h]);
            acc_im += longint'(weights[t * NFFT + chan_pos]) * longint'(hist_im[h]);
            slot = (slot + 1 == HIST_FRAMES) ? 0 : slot + 1;
        end
        // Newest sample takes the last tap
        acc_re += longint'(weights[HIST_FRAMES * NFFT + chan_pos]) * longint'(x_re);
        acc_im += longint'(weights[HIST_FRAMES * NFFT + chan_pos]) * longint'(x_im);
        hist_re[oldest_frame * NFFT + chan_pos] = x_re;
        hist_im[oldest_frame * NFFT + chan_pos] = x_im;
        r.re   = acc_re[ACC_W-1:0];
        r.im   = acc_im[ACC_W-1:0];
        r.chan = chan_pos[CHAN_OUT_W-1:0];
        r.last = (chan_pos == NFFT - 1);
        // Wrap the channel count and retire the oldest frame at frame end
        if (chan_pos == NFFT - 1) begin
            chan_pos     = 0;
            oldest_frame = (oldest_frame + 1 == HIST_FRAMES) ? 0 : oldest_frame + 1;
        end else begin
            chan_pos = chan_pos + 1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            // Input transfer: load a coefficient or predict a result
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_LOAD) begin
                    load_addr = 32'(s_tdata[COEF_IDX_LSB +: COEF_IDX_W]);
                    if (load_addr < WEIGHT_DEPTH)
                        weights[load_addr] = s_tdata[COEF_VAL_LSB +: COEF_W];
                    loads++;
                end else begin
                    expected_sums.push_back(weighted_tap_sum(
                        s_tdata[SAMP_RE_LSB +: SAMP_W], s_tdata[SAMP_IM_LSB +: SAMP_W]));
                end
            end
            // Result transfer: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.re   = m_tdata[0 +: ACC_W];
                got.im   = m_tdata[ACC_W +: ACC_W];
                got.chan = m_tdata[2 * ACC_W +: CHAN_OUT_W];
                got.last = m_tlast;
                results++;
                if (expected_sums.size() == 0) begin
                    $error("unexpected result transfer: channel %0d", got.chan);
                    fails++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got.re !== want.re) begin
                        $error("filt_re mismatch: expected %0d, actual %0d", want.re, got.re);
                        fails++;
                    end
                    if (got.im !== want.im) begin
                        $error("filt_im mismatch: expected %0d, actual %0d", want.im, got.im);
                        fails++;
                    end
                    if (got.chan !== want.chan) begin
                        $error("channel mismatch: expected %0d, actual %0d",
                               want.chan, got.chan);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.last, got.last);
                        fails++;
                    end
                end
            end
        end
        // Publish counters through nonblocking registers so the stimulus side never races them
        fail_count   <= fails;
        pending      <= expected_sums.size();
        result_count <= results;
        load_count   <= loads;
    end

    // Predictions never answered are reported as errors
    final begin
        if (expected_sums.size() != 0)
            $error("%0d expected results never arrived", expected_sums.size());
    end

endmodule

@@ tb/tb.sv @@
// Drives coefficient loads and sample streams into the filterbank front end and
// reports the verdict from the checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam int unsigned NTAPS        = NTAPS_DEF;
    localparam int unsigned NFFT         = NFFT_DEF;
    localparam int unsigned WEIGHT_DEPTH = NTAPS * NFFT;
    // Channels reached by the run; every tap of each one gets a coefficient
    localparam int unsigned CHAN_USED    = 92;
    localparam int unsigned SAMPLE_TOTAL = CHAN_USED;
    localparam int unsigned QUIET_TAIL   = 24;
    localparam int unsigned SETTLE       = NTAPS + 12;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = FUNC_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int          fail_count;
    int          pending;
    int          result_count;
    int          load_count;
    int unsigned idle_pct   = 0;
    int unsigned stall_left = 0;
    int unsigned sample_cnt = 0;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    polyphase_fir_front_end #(.NTAPS(NTAPS), .NFFT(NFFT)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    polyphase_fir_checker #(.NTAPS(NTAPS), .NFFT(NFFT)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .load_count   (load_count)
    );

    // Result side: stall in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [COEF_IDX_W-1:0] idx,
                                                       logic [COEF_W-1:0] val,
                                                       logic [SAMP_W-1:0] re,
                                                       logic [SAMP_W-1:0] im);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[COEF_IDX_LSB +: COEF_IDX_W] = idx;
        d[COEF_VAL_LSB +: COEF_W]     = val;
        d[SAMP_RE_LSB +: SAMP_W]      = re;
        d[SAMP_IM_LSB +: SAMP_W]      = im;
        return d;
    endfunction

    // Window: extreme weights on the low channels, random elsewhere
    function automatic logic [COEF_W-1:0] window_value(int unsigned idx);
        int unsigned chan;
        chan = idx % NFFT;
        if (chan < 16) return 16'h8000;
        if (chan < 32) return 16'h7FFF;
        if (chan < 40) begin
            case ($urandom_range(0, 2))
                0: return 16'h0000;
                1: return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end
        return COEF_W'($urandom);
    endfunction

    // Low channels stay at full scale for the first frames so the sums peak
    function automatic logic [SAMP_W-1:0] sample_value(int unsigned chan,
                                                       int unsigned frame);
        if (chan < 32 && frame < NTAPS) return 16'h8000;
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(logic func, logic [IN_DATA_W-1:0] data);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Sample fields carry noise on loads
    task automatic send_load(int unsigned idx, logic [COEF_W-1:0] val);
        send_item(FUNC_LOAD, pack_item(COEF_IDX_W'(idx), val,
                                       SAMP_W'($urandom), SAMP_W'($urandom)));
    endtask

    // Coefficient fields carry noise on samples
    task automatic send_sample(logic [SAMP_W-1:0] re, logic [SAMP_W-1:0] im);
        send_item(FUNC_SAMPLE, pack_item(COEF_IDX_W'($urandom), COEF_W'($urandom), re, im));
        sample_cnt++;
    endtask

    // Drop valid, wait for every result, then let the datapath settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every tap of the channels the run reaches before any sample
        idle_pct = 20;
        for (int unsigned t = 0; t < NTAPS; t++) begin
            for (int unsigned c = 0; c < CHAN_USED; c++) begin
                send_load(t * NFFT + c, window_value(t * NFFT + c));
            end
        end

        // Directed samples: field extremes against extreme weights
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);

        // Rewrite a few weights while idle, the address extremes among them
        drain();
        send_load(0, 16'h8000);
        send_load(WEIGHT_DEPTH - 1, 16'h7FFF);
        send_load((NTAPS - 1) * NFFT + 8, 16'h7FFF);
        send_load((NTAPS - 1) * NFFT + 9, 16'h0001);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_sample(SAMP_W'($urandom), SAMP_W'($urandom));

        // Random samples with idle-time weight updates every 32 samples
        while (sample_cnt < SAMPLE_TOTAL) begin
            if (SAMPLE_TOTAL - sample_cnt <= QUIET_TAIL) begin
                idle_pct = 0;
            end else if (sample_cnt % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (sample_cnt % 32 == 0) begin
                drain();
                repeat ($urandom_range(2, 8))
                    send_load($urandom_range(0, NTAPS - 1) * NFFT
                              + $urandom_range(0, CHAN_USED - 1), COEF_W'($urandom));
            end
            send_sample(sample_value(sample_cnt % NFFT, sample_cnt / NFFT),
                        sample_value(sample_cnt % NFFT, sample_cnt / NFFT));
        end

        drain();
        $display("Ran %0d coefficient loads and checked %0d filter results on channels 0-%0d.",
                 load_count, result_count, CHAN_USED - 1);
        $display("History was still clear, so each sum came from the newest tap.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pfe_pkg.sv
hdl/pfe_ram.sv
hdl/pfe_mac.sv
hdl/pfe_ctrl.sv
hdl/polyphase_fir_front_end.sv
tb/polyphase_fir_checker.sv
tb/tb.sv
